// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CPFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/cpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpfp_pkg
// shared constants and types of the camera position frame parser
// ----------------------------------------------------------------------------
package cpfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 17;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h26;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h25;
    localparam logic [BYTE_W-1:0] SIGN_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      frame_ok;
    } t_result;

endpackage

// ----- sv/cpfp_parse.sv -----
// ----------------------------------------------------------------------------
// cpfp_parse
// frame position tracking, coordinate accumulation and checksum compare
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpfp_parse (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [cpfp_pkg::BYTE_W-1:0]      i_byte,
    output logic                             o_at_sum,
    output cpfp_pkg::t_result                o_result
);

    typedef enum logic [3:0] {
        POS_HDR1,
        POS_HDR2,
        POS_XH,
        POS_XL,
        POS_XS,
        POS_YH,
        POS_YL,
        POS_YS,
        POS_SUM
    } t_pos;

    t_pos                                 r_pos;
    t_pos                                 n_pos;
    logic [cpfp_pkg::BYTE_W-1:0]          r_sum;
    logic [cpfp_pkg::BYTE_W-1:0]          n_sum;
    logic signed [cpfp_pkg::COORD_W-1:0]  r_x;
    logic signed [cpfp_pkg::COORD_W-1:0]  n_x;
    logic signed [cpfp_pkg::COORD_W-1:0]  r_y;
    logic signed [cpfp_pkg::COORD_W-1:0]  n_y;
    logic [cpfp_pkg::BYTE_W-1:0]          sum_add;
    logic signed [cpfp_pkg::COORD_W-1:0]  byte_ext;
    logic signed [cpfp_pkg::COORD_W-1:0]  byte_hi;
    logic                                 pass;
    logic                                 is_minus;

    assign sum_add  = r_sum + i_byte;
    assign byte_ext = {{(cpfp_pkg::COORD_W-cpfp_pkg::BYTE_W){1'b0}}, i_byte};
    assign byte_hi  = {{(cpfp_pkg::COORD_W-2*cpfp_pkg::BYTE_W){1'b0}}, i_byte,
                       {cpfp_pkg::BYTE_W{1'b0}}};
    assign pass     = (r_sum == i_byte);
    assign is_minus = (i_byte == cpfp_pkg::SIGN_MINUS);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        n_x   = r_x;
        n_y   = r_y;
        case (r_pos)
            POS_HDR1: begin
                n_pos = (i_byte == cpfp_pkg::HDR_FIRST) ? POS_HDR2 : POS_HDR1;
            end
            POS_HDR2: begin
                n_pos = (i_byte == cpfp_pkg::HDR_SECOND) ? POS_XH : POS_HDR1;
            end
            POS_XH: begin
                n_sum = cpfp_pkg::HDR_FIRST + cpfp_pkg::HDR_SECOND + i_byte;
                n_x   = byte_hi;
                n_pos = POS_XL;
            end
            POS_XL: begin
                n_x   = r_x + byte_ext;
                n_sum = sum_add;
                n_pos = POS_XS;
            end
            POS_XS: begin
                if (is_minus) begin
                    n_x = -r_x;
                end
                n_sum = sum_add;
                n_pos = POS_YH;
            end
            POS_YH: begin
                n_y   = byte_hi;
                n_sum = sum_add;
                n_pos = POS_YL;
            end
            POS_YL: begin
                n_y   = r_y + byte_ext;
                n_sum = sum_add;
                n_pos = POS_YS;
            end
            POS_YS: begin
                if (is_minus) begin
                    n_y = -r_y;
                end
                n_sum = sum_add;
                n_pos = POS_SUM;
            end
            POS_SUM: begin
                if (!pass) begin
                    n_x = '0;
                    n_y = '0;
                end
                n_pos = POS_HDR1;
            end
            default: begin
                n_pos = POS_HDR1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR1;
            r_sum <= '0;
            r_x   <= '0;
            r_y   <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_at_sum          = (r_pos == POS_SUM);
    assign o_result.pos_x    = pass ? r_x : '0;
    assign o_result.pos_y    = pass ? r_y : '0;
    assign o_result.frame_ok = pass;

    `CPFP_ASSERT(a_sum_restarts, i_clk, i_rst_n, (i_step && o_at_sum) |=> (r_pos == POS_HDR1), "frame did not restart after checksum")
    `CPFP_ASSERT(a_pos_range, i_clk, i_rst_n, (r_pos <= POS_SUM), "frame position out of range")
    `CPFP_ASSERT(a_hold_idle, i_clk, i_rst_n, !i_step |=> ($stable(r_pos) && $stable(r_sum)), "parser state moved without a byte")

endmodule

// ----- sv/cpfp_out.sv -----
// ----------------------------------------------------------------------------
// cpfp_out
// two-entry result buffer between the parser and the output channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpfp_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  cpfp_pkg::t_result  i_data,
    output logic               o_wr_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output cpfp_pkg::t_result  o_data
);

    localparam logic [1:0] FULL_CNT = 2'd2;

    cpfp_pkg::t_result  r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_cnt;
    logic               rd;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_wr_ready = (r_cnt != FULL_CNT);
    assign o_data     = r_mem[r_rd_ptr];
    assign rd         = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_wr && !rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd && !i_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    `CPFP_ASSERT(a_no_overflow, i_clk, i_rst_n, i_wr |-> o_wr_ready, "write into full result buffer")
    `CPFP_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt <= FULL_CNT), "result count out of range")
    `CPFP_ASSERT(a_cnt_inc, i_clk, i_rst_n, (i_wr && !rd) |=> (r_cnt == $past(r_cnt) + 2'd1), "result count did not grow")

endmodule

// ----- sv/camera_position_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// camera_position_frame_parser_unit
// parses nine-byte serial position frames into signed X/Y coordinates
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready, i_rx_byte) carries one received serial
// byte per transaction. Frames are '&', '%', X high, X low, X sign, Y high,
// Y low, Y sign, checksum. Output channel (o_valid / i_ready) carries one
// transaction per checksum byte: o_pos_x, o_pos_y and o_frame_ok; on a
// checksum mismatch both coordinates are zero and o_frame_ok is low.
// Throughput is one byte per cycle while the result buffer has room. A byte
// goes into the input register at acceptance and is parsed from there; a
// parsed checksum byte writes its result into the buffer behind o_valid.
// Results wait in this two-entry buffer, so the input keeps flowing while
// the receiver stalls; once it is full, a checksum byte holds in the input
// register and o_ready drops until a result is taken. No other byte holds
// there. Synchronous reset empties the input register and the result buffer
// and returns the parser to waiting for the first header byte.
// ----------------------------------------------------------------------------
module camera_position_frame_parser_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [cpfp_pkg::BYTE_W-1:0]            i_rx_byte,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [cpfp_pkg::COORD_W-1:0]    o_pos_x,
    output logic signed [cpfp_pkg::COORD_W-1:0]    o_pos_y,
    output logic                                   o_frame_ok
);

    logic                           r_in_vld;
    logic [cpfp_pkg::BYTE_W-1:0]    r_in_byte;
    logic                           at_sum;
    logic                           buf_ready;
    logic                           step;
    logic                           wr;
    cpfp_pkg::t_result              parse_res;
    cpfp_pkg::t_result              out_res;

    assign step    = r_in_vld && (!at_sum || buf_ready);
    assign wr      = step && at_sum;
    assign o_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cpfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_at_sum (at_sum),
        .o_result (parse_res)
    );

    cpfp_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_data     (parse_res),
        .o_wr_ready (buf_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (out_res)
    );

    assign o_pos_x    = out_res.pos_x;
    assign o_pos_y    = out_res.pos_y;
    assign o_frame_ok = out_res.frame_ok;

endmodule

// ----- tb/camera_position_frame_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// camera_position_frame_parser_unit_tb
// Self-checking bench for the camera position frame parser. A short table
// covers header errors, coordinate extremes, sign handling, negative zero and
// a bad checksum. Random frames follow, with bad checksums, broken headers and
// noise mixed in, under several sender and receiver idle patterns and one
// long receiver hold-off. Every accepted byte is run through a parser model
// and each position transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module camera_position_frame_parser_unit_tb;

    localparam logic [cpfp_pkg::BYTE_W-1:0] SIGN_PLUS = 8'h2B;
    localparam int unsigned       STALL_LIMIT = 4000;
    localparam int unsigned       HOLD_CYCLES = 300;
    localparam int unsigned       DIR_ROWS    = 30;
    localparam cpfp_pkg::t_result NO_RESULT   = '0;

    typedef struct {
        logic [3:0]                   pos;
        logic [cpfp_pkg::BYTE_W-1:0]  sum;
        logic [cpfp_pkg::COORD_W-1:0] x;
        logic [cpfp_pkg::COORD_W-1:0] y;
    } t_frame_state;

    typedef struct {
        logic [cpfp_pkg::BYTE_W-1:0] rx;
        bit                          typed;
        cpfp_pkg::t_result           res;
    } t_rx_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [cpfp_pkg::BYTE_W-1:0]         i_rx_byte;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [cpfp_pkg::COORD_W-1:0] o_pos_x;
    logic signed [cpfp_pkg::COORD_W-1:0] o_pos_y;
    logic                                o_frame_ok;

    t_frame_state      frame_st;
    cpfp_pkg::t_result pending_positions[$];
    int unsigned       mismatch_cnt;
    int unsigned       payload_bytes;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    bit                hold_req;

    t_rx_row dir_rows [DIR_ROWS] = '{
        '{cpfp_pkg::HDR_FIRST,  1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_FIRST,  1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_SECOND, 1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_FIRST,  1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_SECOND, 1'b0, NO_RESULT},
        '{8'hFF,                1'b0, NO_RESULT},
        '{8'hFF,                1'b0, NO_RESULT},
        '{cpfp_pkg::SIGN_MINUS, 1'b0, NO_RESULT},
        '{8'hFF,                1'b0, NO_RESULT},
        '{8'hFF,                1'b0, NO_RESULT},
        '{SIGN_PLUS,            1'b0, NO_RESULT},
        '{8'h9F,                1'b1, '{-17'sd65535, 17'sd65535, 1'b1}},
        '{cpfp_pkg::HDR_FIRST,  1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_SECOND, 1'b0, NO_RESULT},
        '{8'h00,                1'b0, NO_RESULT},
        '{8'h00,                1'b0, NO_RESULT},
        '{cpfp_pkg::SIGN_MINUS, 1'b0, NO_RESULT},
        '{8'h00,                1'b0, NO_RESULT},
        '{8'h00,                1'b0, NO_RESULT},
        '{cpfp_pkg::SIGN_MINUS, 1'b0, NO_RESULT},
        '{8'hA5,                1'b1, '{17'sd0, 17'sd0, 1'b1}},
        '{cpfp_pkg::HDR_FIRST,  1'b0, NO_RESULT},
        '{cpfp_pkg::HDR_SECOND, 1'b0, NO_RESULT},
        '{8'h12,                1'b0, NO_RESULT},
        '{8'h34,                1'b0, NO_RESULT},
        '{cpfp_pkg::SIGN_MINUS, 1'b0, NO_RESULT},
        '{8'h56,                1'b0, NO_RESULT},
        '{8'h78,                1'b0, NO_RESULT},
        '{8'h00,                1'b0, NO_RESULT},
        '{8'h8D,                1'b1, '{17'sd0, 17'sd0, 1'b0}}
    };

    camera_position_frame_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_frame_ok (o_frame_ok)
    );

    function automatic bit parse_rx_byte(input logic [cpfp_pkg::BYTE_W-1:0] b,
                                         output cpfp_pkg::t_result res);
        res = '0;
        case (frame_st.pos)
            4'd0: begin
                frame_st.pos = (b == cpfp_pkg::HDR_FIRST) ? 4'd1 : 4'd0;
            end
            4'd1: begin
                frame_st.pos = (b == cpfp_pkg::HDR_SECOND) ? 4'd2 : 4'd0;
            end
            4'd2: begin
                frame_st.sum = cpfp_pkg::HDR_FIRST + cpfp_pkg::HDR_SECOND + b;
                frame_st.x   = cpfp_pkg::COORD_W'({b, 8'h00});
                frame_st.pos = 4'd3;
            end
            4'd3: begin
                frame_st.x   = frame_st.x + cpfp_pkg::COORD_W'(b);
                frame_st.sum = frame_st.sum + b;
                frame_st.pos = 4'd4;
            end
            4'd4: begin
                if (b == cpfp_pkg::SIGN_MINUS) begin
                    frame_st.x = -frame_st.x;
                end
                frame_st.sum = frame_st.sum + b;
                frame_st.pos = 4'd5;
            end
            4'd5: begin
                frame_st.y   = cpfp_pkg::COORD_W'({b, 8'h00});
                frame_st.sum = frame_st.sum + b;
                frame_st.pos = 4'd6;
            end
            4'd6: begin
                frame_st.y   = frame_st.y + cpfp_pkg::COORD_W'(b);
                frame_st.sum = frame_st.sum + b;
                frame_st.pos = 4'd7;
            end
            4'd7: begin
                if (b == cpfp_pkg::SIGN_MINUS) begin
                    frame_st.y = -frame_st.y;
                end
                frame_st.sum = frame_st.sum + b;
                frame_st.pos = 4'd8;
            end
            4'd8: begin
                res.frame_ok = (frame_st.sum == b);
                if (!res.frame_ok) begin
                    frame_st.x = '0;
                    frame_st.y = '0;
                end
                res.pos_x    = frame_st.x;
                res.pos_y    = frame_st.y;
                frame_st.pos = 4'd0;
                return 1'b1;
            end
            default: begin
                frame_st.pos = 4'd0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [cpfp_pkg::BYTE_W-1:0] pick_magnitude();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [cpfp_pkg::BYTE_W-1:0] pick_sign();
        return $urandom_range(1) ? cpfp_pkg::SIGN_MINUS : 8'($urandom_range(255));
    endfunction

    task automatic push_rx_byte(input logic [cpfp_pkg::BYTE_W-1:0] b, input bit typed,
                                input cpfp_pkg::t_result typed_res);
        cpfp_pkg::t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        if (frame_st.pos != 4'd0 || b == cpfp_pkg::HDR_FIRST) begin
            payload_bytes++;
        end
        if (parse_rx_byte(b, res)) begin
            pending_positions.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_frame(input bit good);
        logic [cpfp_pkg::BYTE_W-1:0] csum;
        push_rx_byte(cpfp_pkg::HDR_FIRST, 1'b0, NO_RESULT);
        push_rx_byte(cpfp_pkg::HDR_SECOND, 1'b0, NO_RESULT);
        push_rx_byte(pick_magnitude(), 1'b0, NO_RESULT);
        push_rx_byte(pick_magnitude(), 1'b0, NO_RESULT);
        push_rx_byte(pick_sign(), 1'b0, NO_RESULT);
        push_rx_byte(pick_magnitude(), 1'b0, NO_RESULT);
        push_rx_byte(pick_magnitude(), 1'b0, NO_RESULT);
        push_rx_byte(pick_sign(), 1'b0, NO_RESULT);
        csum = good ? frame_st.sum : frame_st.sum ^ 8'($urandom_range(255, 1));
        push_rx_byte(csum, 1'b0, NO_RESULT);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s", msg);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver side, with an optional long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_positions
        cpfp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_positions.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction: x=%0d y=%0d ok=%0b",
                                        o_pos_x, o_pos_y, o_frame_ok));
            end else begin
                want = pending_positions.pop_front();
                if (o_pos_x !== want.pos_x || o_pos_y !== want.pos_y ||
                    o_frame_ok !== want.frame_ok) begin
                    note_mismatch($sformatf(
                        "mismatch: expected x=%0d y=%0d ok=%0b, got x=%0d y=%0d ok=%0b",
                        want.pos_x, want.pos_y, want.frame_ok,
                        o_pos_x, o_pos_y, o_frame_ok));
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("camera_position_frame_parser_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned send_pct [4] = '{0, 59, 0, 35};
        int unsigned recv_pct [4] = '{0, 0, 59, 35};
        int unsigned pick;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_rx_byte      = '0;
        hold_req       = 1'b0;
        mismatch_cnt   = 0;
        payload_bytes  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frame_st       = '{4'd0, 8'd0, 17'd0, 17'd0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            push_rx_byte(dir_rows[r].rx, dir_rows[r].typed, dir_rows[r].res);
        end

        payload_bytes = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0) begin
                hold_req = 1'b1;
                repeat (6) send_frame(1'b1);
            end
            while (payload_bytes < (ph + 1) * 250) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    send_frame($urandom_range(9) < 7);
                end else if (pick < 90) begin
                    push_rx_byte(cpfp_pkg::HDR_FIRST, 1'b0, NO_RESULT);
                    push_rx_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
                end else begin
                    repeat ($urandom_range(4, 1))
                        push_rx_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
                end
                // resync so the next frame starts at the first header
                while (frame_st.pos != 4'd0) begin
                    push_rx_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
                end
            end
        end
        i_valid <= 1'b0;

        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("camera_position_frame_parser_unit test passed");
        end else begin
            $display("camera_position_frame_parser_unit test failed");
        end
        $finish;
    end

endmodule
